// ===== hdl/mat3inv_pkg.sv =====
// shared constants, cofactor index tables and control types of the 3x3 inverse
`default_nettype none

package mat3inv_pkg;

    // nine elements per matrix, row-major: index = 3*row + column
    localparam int LANES = 9;

    typedef logic [3:0] elem_idx_t;

    // cofactor k = m[P]*m[Q] - m[R]*m[S], negated when NEG is set
    localparam elem_idx_t COF_P [LANES] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
    localparam elem_idx_t COF_Q [LANES] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
    localparam elem_idx_t COF_R [LANES] = '{4'd7, 4'd7, 4'd4, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd3};
    localparam elem_idx_t COF_S [LANES] = '{4'd5, 4'd2, 4'd2, 4'd5, 4'd2, 4'd2, 4'd4, 4'd1, 4'd1};
    localparam logic      COF_NEG [LANES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    // adjugate entries of column 0 that expand the determinant along row 0
    localparam int DET_ADJ [3] = '{0, 3, 6};

    // item status leaving the divider
    typedef struct packed {
        logic valid;
        logic singular;
    } mat3inv_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/mat3inv_in_if.sv =====
// input channel: one 3x3 matrix per item
`default_nettype none

interface mat3inv_in_if #(
    parameter int W = 32
);
    logic valid;
    logic ready;
    logic signed [W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
    modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

`default_nettype wire

// ===== hdl/mat3inv_out_if.sv =====
// output channel: one inverse matrix and singular flag per item
`default_nettype none

interface mat3inv_out_if #(
    parameter int W = 32
);
    logic valid;
    logic ready;
    logic signed [W-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic singular;

    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, singular, input ready);
    modport sink (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, singular, output ready);
endinterface

`default_nettype wire

// ===== hdl/mat3inv_cof.sv =====
// cofactor and determinant stages: pair products, adjugate, split products, sum
`default_nettype none

module mat3inv_cof
    import mat3inv_pkg::*;
#(
    parameter int E = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [E-1:0]   a [LANES],
    output logic                  out_valid,
    output logic signed [2*E:0]   adj [LANES],
    output logic signed [3*E+2:0] det
);
    localparam int PW = 2 * E;
    localparam int AW = 2 * E + 1;
    localparam int DW = 3 * E + 3;

    logic [3:0] v_reg;

    logic signed [PW-1:0] p1_reg [LANES];
    logic signed [PW-1:0] p2_reg [LANES];
    logic signed [E-1:0]  row1_reg [3];
    logic signed [AW-1:0] adj2_reg [LANES];
    logic signed [E-1:0]  row2_reg [3];
    logic signed [AW-1:0] adj3_reg [LANES];
    logic signed [AW-1:0] plo_reg [3];
    logic signed [AW-1:0] phi_reg [3];
    logic signed [AW-1:0] adj4_reg [LANES];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;

    // valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // stage 1: pair products, stage 2: adjugate entries
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p1_reg[k]   <= a[COF_P[k]] * a[COF_Q[k]];
                p2_reg[k]   <= a[COF_R[k]] * a[COF_S[k]];
                adj2_reg[k] <= COF_NEG[k]
                    ? $signed({p2_reg[k][PW-1], p2_reg[k]}) - $signed({p1_reg[k][PW-1], p1_reg[k]})
                    : $signed({p1_reg[k][PW-1], p1_reg[k]}) - $signed({p2_reg[k][PW-1], p2_reg[k]});
                adj3_reg[k] <= adj2_reg[k];
                adj4_reg[k] <= adj3_reg[k];
            end
        end
    end

    // stage 3: row element times low and high halves of its cofactor
    for (genvar j = 0; j < 3; j++)
    begin : g_row
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                row1_reg[j] <= a[j];
                row2_reg[j] <= row1_reg[j];
                plo_reg[j]  <= row2_reg[j] * $signed({1'b0, adj2_reg[DET_ADJ[j]][E-1:0]});
                phi_reg[j]  <= row2_reg[j] * $signed(adj2_reg[DET_ADJ[j]][AW-1:E]);
            end
        end
    end

    // stage 4: recombine the partial products into the determinant
    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DW'(phi_reg[j]) <<< E) + DW'(plo_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= det_next;
        end
    end

    assign out_valid = v_reg[3];
    assign adj       = adj4_reg;
    assign det       = det_reg;

endmodule

`default_nettype wire

// ===== hdl/mat3inv_div.sv =====
// divider pipeline: magnitudes, overflow test, one quotient bit per stage per lane
`default_nettype none

module mat3inv_div
    import mat3inv_pkg::*;
#(
    parameter int E = 32,
    parameter int F = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [2*E:0]   adj [LANES],
    input  logic signed [3*E+2:0] det,
    output mat3inv_ctl_t          ctl,
    output logic [LANES-1:0]      neg,
    output logic [LANES-1:0]      ovf,
    output logic [E-1:0]          quo [LANES]
);
    localparam int AW = 2 * E + 1;
    localparam int DW = 3 * E + 3;
    localparam int RW = 4 * E + 2 * F + 3;

    // stage a: magnitudes and signs
    logic                 va_reg;
    logic                 sing_a_reg;
    logic [DW-1:0]        dmag_a_reg;
    logic [LANES-1:0]     neg_a_reg;
    logic [RW-1:0]        num_a_reg [LANES];

    // stage b onward: division stages, index 0 is the overflow stage
    logic                 v_st    [E+1];
    logic                 sing_st [E+1];
    logic [LANES-1:0]     neg_st  [E+1];
    logic [LANES-1:0]     ovf_st  [E+1];
    logic [RW-1:0]        d_st    [E];
    logic [RW-1:0]        r_st    [E][LANES];
    logic [E-1:0]         q_st    [E+1][LANES];

    // valid bits of stage a and b
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            v_st[0]  <= 1'b0;
        end
        else if (en)
        begin
            va_reg   <= in_valid;
            v_st[0]  <= va_reg;
        end
    end

    // stage a: absolute values and numerator alignment
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_a_reg <= (det == '0);
            dmag_a_reg <= det[DW-1] ? DW'(-det) : DW'(det);
            for (int k = 0; k < LANES; k++)
            begin
                neg_a_reg[k] <= adj[k][AW-1] ^ det[DW-1];
                num_a_reg[k] <= (adj[k][AW-1] ? RW'(AW'(-adj[k])) : RW'(AW'(adj[k])))
                    << (2 * F);
            end
        end
    end

    // stage b: quotient overflow when numerator reaches divisor times 2^E
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_st[0] <= sing_a_reg;
            neg_st[0]  <= neg_a_reg;
            d_st[0]    <= RW'(dmag_a_reg);
            for (int k = 0; k < LANES; k++)
            begin
                ovf_st[0][k] <= num_a_reg[k] >= (RW'(dmag_a_reg) << E);
                r_st[0][k]   <= num_a_reg[k];
                q_st[0][k]   <= '0;
            end
        end
    end

    // restoring division, quotient bit E-1-g decided in stage g
    for (genvar g = 0; g < E; g++)
    begin : g_step
        logic [RW-1:0]    trial;
        logic [LANES-1:0] take;

        assign trial = d_st[g] << (E - 1 - g);

        always_comb
        begin
            for (int k = 0; k < LANES; k++)
            begin
                take[k] = r_st[g][k] >= trial;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_st[g+1] <= 1'b0;
            end
            else if (en)
            begin
                v_st[g+1] <= v_st[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sing_st[g+1] <= sing_st[g];
                neg_st[g+1]  <= neg_st[g];
                ovf_st[g+1]  <= ovf_st[g];
                for (int k = 0; k < LANES; k++)
                begin
                    q_st[g+1][k] <= {q_st[g][k][E-2:0], take[k]};
                end
            end
        end

        // remainder and divisor go on only to stages that still need them
        if (g < E - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_st[g+1] <= d_st[g];
                    for (int k = 0; k < LANES; k++)
                    begin
                        r_st[g+1][k] <= take[k] ? r_st[g][k] - trial : r_st[g][k];
                    end
                end
            end
        end
    end

    assign ctl.valid    = v_st[E];
    assign ctl.singular = sing_st[E];
    assign neg          = neg_st[E];
    assign ovf          = ovf_st[E];
    assign quo          = q_st[E];

endmodule

`default_nettype wire

// ===== hdl/matrix3x3_inverse_top.sv =====
// top level of the pipelined 3x3 fixed-point matrix inverse
`default_nettype none

// Inverts one 3x3 matrix of signed fixed-point elements (ELEM_WIDTH bits,
// FRAC_BITS fraction bits) per item through the adjugate. A new item is
// accepted every cycle while the output is not stalled; the pipeline runs
// through the multiplier stages for cofactors and determinant, the
// magnitude and overflow-test stages, one restoring divider step per
// quotient bit in each of nine lanes, and the saturating output register.
// The whole pipeline advances together and holds while a result waits at the
// output. Quotients are truncated toward zero and saturated to the element
// range; a zero determinant gives all-zero elements with singular set.
module matrix3x3_inverse_top
    import mat3inv_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    mat3inv_in_if.sink   in_ch,
    mat3inv_out_if.source out_ch
);
    localparam int E  = ELEM_WIDTH;
    localparam logic [E-1:0] POS_LIM = {1'b0, {(E-1){1'b1}}};
    localparam logic [E-1:0] NEG_LIM = {1'b1, {(E-1){1'b0}}};

    logic                  en;
    logic signed [E-1:0]   a_in [LANES];
    logic                  cof_valid;
    logic signed [2*E:0]   adj [LANES];
    logic signed [3*E+2:0] det;
    mat3inv_ctl_t          div_ctl;
    logic [LANES-1:0]      div_neg;
    logic [LANES-1:0]      div_ovf;
    logic [E-1:0]          div_quo [LANES];

    logic                  out_valid_reg;
    logic                  sing_reg;
    logic [E-1:0]          inv_reg  [LANES];
    logic [E-1:0]          inv_next [LANES];

    // pipeline advances unless a finished item is stuck at the output
    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    assign a_in[0] = in_ch.a00;
    assign a_in[1] = in_ch.a01;
    assign a_in[2] = in_ch.a02;
    assign a_in[3] = in_ch.a10;
    assign a_in[4] = in_ch.a11;
    assign a_in[5] = in_ch.a12;
    assign a_in[6] = in_ch.a20;
    assign a_in[7] = in_ch.a21;
    assign a_in[8] = in_ch.a22;

    mat3inv_cof #(.E(E)) u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_ch.valid),
        .a         (a_in),
        .out_valid (cof_valid),
        .adj       (adj),
        .det       (det)
    );

    mat3inv_div #(.E(E), .F(FRAC_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (cof_valid),
        .adj      (adj),
        .det      (det),
        .ctl      (div_ctl),
        .neg      (div_neg),
        .ovf      (div_ovf),
        .quo      (div_quo)
    );

    // sign and saturation of each quotient
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (div_ctl.singular)
            begin
                inv_next[k] = '0;
            end
            else if (div_neg[k])
            begin
                inv_next[k] = (div_ovf[k] || (div_quo[k] > NEG_LIM)) ? NEG_LIM : -div_quo[k];
            end
            else
            begin
                inv_next[k] = (div_ovf[k] || div_quo[k][E-1]) ? POS_LIM : div_quo[k];
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= div_ctl.singular;
            inv_reg  <= inv_next;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.singular = sing_reg;
    assign out_ch.inv00    = inv_reg[0];
    assign out_ch.inv01    = inv_reg[1];
    assign out_ch.inv02    = inv_reg[2];
    assign out_ch.inv10    = inv_reg[3];
    assign out_ch.inv11    = inv_reg[4];
    assign out_ch.inv12    = inv_reg[5];
    assign out_ch.inv20    = inv_reg[6];
    assign out_ch.inv21    = inv_reg[7];
    assign out_ch.inv22    = inv_reg[8];

    // input side follows the output stall
    a_ready_follows_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready == (!out_ch.valid || out_ch.ready))
        else $error("input ready does not follow output stall");

    // a stalled result stays and keeps its flag
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.singular)
            && $stable(out_ch.inv00) && $stable(out_ch.inv22))
        else $error("stalled result changed");

    // singular items carry zero elements
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.singular |-> out_ch.inv00 == '0 && out_ch.inv11 == '0
            && out_ch.inv22 == '0 && out_ch.inv01 == '0)
        else $error("singular item with nonzero elements");

endmodule

`default_nettype wire

// ===== tb/matrix3x3_inverse_top_tb.sv =====
// testbench of the 3x3 fixed-point matrix inverse: directed and random matrices
`default_nettype none

module matrix3x3_inverse_top_tb;
    import mat3inv_pkg::*;

    localparam int W = 32;
    localparam int FB = 16;
    localparam int LAT = W + 7;
    localparam longint LIMIT = 400000;

    typedef logic signed [W-1:0] elem_t;
    typedef struct {
        elem_t m [9];
        logic  singular;
    } inverse_t;

    logic clk;
    logic rst_n;
    mat3inv_in_if  #(.W(W)) in_ch ();
    mat3inv_out_if #(.W(W)) out_ch ();

    matrix3x3_inverse_top #(.ELEM_WIDTH(W), .FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    inverse_t expected_inverses [$];
    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    longint cycles;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // exact inverse with truncation toward zero and saturation
    function automatic inverse_t predict_inverse(elem_t a [9]);
        inverse_t r;
        logic signed [127:0] e [9];
        logic signed [127:0] det, cof, num, quo;
        logic signed [127:0] pmax, nmin;
        int p [9];
        int q [9];
        int s [9];
        int t [9];
        bit ng [9];
        p = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
        q = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
        s = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
        t = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
        ng = '{0, 1, 0, 1, 0, 1, 0, 1, 0};
        pmax = (128'sd1 <<< (W - 1)) - 1;
        nmin = -(128'sd1 <<< (W - 1));
        for (int k = 0; k < 9; k++)
            e[k] = a[k];
        det = e[0]*e[4]*e[8] + e[3]*e[7]*e[2] + e[6]*e[1]*e[5]
            - e[6]*e[4]*e[2] - e[3]*e[1]*e[8] - e[0]*e[7]*e[5];
        r.singular = (det == 0);
        for (int k = 0; k < 9; k++)
        begin
            if (r.singular)
            begin
                r.m[k] = '0;
            end
            else
            begin
                cof = e[p[k]]*e[q[k]] - e[s[k]]*e[t[k]];
                if (ng[k])
                    cof = -cof;
                num = cof <<< (2 * FB);
                quo = num / det;
                if (quo > pmax)
                    quo = pmax;
                if (quo < nmin)
                    quo = nmin;
                r.m[k] = quo[W-1:0];
            end
        end
        return r;
    endfunction

    // send one matrix, recording its expected inverse on acceptance
    task automatic send_matrix(elem_t a [9]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.a00, in_ch.a01, in_ch.a02, in_ch.a10, in_ch.a11, in_ch.a12,
         in_ch.a20, in_ch.a21, in_ch.a22} <= {a[0], a[1], a[2], a[3], a[4],
                                             a[5], a[6], a[7], a[8]};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_inverses.push_back(predict_inverse(a));
        @(negedge clk);
    endtask

    // receiver stalls
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // compare each inverse with the oldest expectation
    always @(posedge clk)
    begin
        inverse_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.m = '{out_ch.inv00, out_ch.inv01, out_ch.inv02, out_ch.inv10,
                      out_ch.inv11, out_ch.inv12, out_ch.inv20, out_ch.inv21,
                      out_ch.inv22};
            got.singular = out_ch.singular;
            if (expected_inverses.size() == 0)
            begin
                $display("%0t unexpected item singular=%b", $time, got.singular);
                errors++;
            end
            else
            begin
                want = expected_inverses.pop_front();
                if (got.singular !== want.singular)
                begin
                    $display("%0t singular expected %b actual %b", $time,
                             want.singular, got.singular);
                    errors++;
                end
                for (int k = 0; k < 9; k++)
                    if (got.m[k] !== want.m[k])
                    begin
                        $display("%0t inv[%0d] expected %h actual %h", $time, k,
                                 want.m[k], got.m[k]);
                        errors++;
                    end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic elem_t rand_elem(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(8)) * 32'sh8000 - 32'sh20000;
            2: return $signed(32'($urandom_range(131072 * 2))) - 32'sh20000;
            default: return $signed(32'($urandom_range(16 * 65536)))
                            - 32'sh80000;
        endcase
    endfunction

    task automatic test_directed();
        elem_t a [9];
        elem_t mx, mn, one;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        one = 32'sh10000;
        a = '{one, 0, 0, 0, one, 0, 0, 0, one};
        send_matrix(a);
        a = '{-one, 0, 0, 0, -one, 0, 0, 0, -one};
        send_matrix(a);
        a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(a);
        a = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 9*one};
        send_matrix(a);
        a = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};
        send_matrix(a);
        a = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};
        send_matrix(a);
        a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(a);
        a = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(a);
        a = '{mn, mx, mn, mx, mn, mx, mn, mx, mx};
        send_matrix(a);
        a = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
        send_matrix(a);
        a = '{mn, mx, 1, -1, mn, mx, 0, -1, mn};
        send_matrix(a);
        a = '{2*one, one, 0, one, 3*one, one, 0, one, 4*one};
        send_matrix(a);
        a = '{0, one, 0, 0, 0, one, one, 0, 0};
        send_matrix(a);
        a = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_matrix(a);
        a = '{3, 1, 0, 0, 2, 0, 0, 0, 5};
        send_matrix(a);
    endtask

    task automatic test_random(int n);
        elem_t a [9];
        int mode;
        for (int i = 0; i < n; i++)
        begin
            mode = $urandom_range(3);
            for (int k = 0; k < 9; k++)
                a[k] = rand_elem(mode);
            // occasionally make rows dependent to hit a zero determinant
            if ($urandom_range(9) == 0)
                for (int k = 0; k < 3; k++)
                    a[6 + k] = a[k];
            send_matrix(a);
        end
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (expected_inverses.size() != 0)
            @(posedge clk);
        repeat (LAT + 5) @(posedge clk);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 31;
        recv_idle_pct = 73;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        out_ch.ready = 1'b0;
        {in_ch.a00, in_ch.a01, in_ch.a02, in_ch.a10, in_ch.a11, in_ch.a12,
         in_ch.a20, in_ch.a21, in_ch.a22} = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(330);
        send_idle_pct = 73;
        recv_idle_pct = 31;
        test_random(330);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(340);
        wait_drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/mat3inv_pkg.sv
hdl/mat3inv_in_if.sv
hdl/mat3inv_out_if.sv
hdl/mat3inv_cof.sv
hdl/mat3inv_div.sv
hdl/matrix3x3_inverse_top.sv
tb/matrix3x3_inverse_top_tb.sv
